// ===== design/rlfw_pkg.sv =====
`default_nettype none
package rlfw_pkg;

  localparam int NumThreads = 16;
  localparam int QueueDepth = 16;
  localparam int DepthBits  = 8;

  localparam int ThreadW = 4;
  localparam int PtrW    = $clog2(QueueDepth);
  localparam int CntW    = $clog2(QueueDepth + 1);

  typedef enum logic {
    CmdRequest = 1'b0,
    CmdRelease = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    StGranted       = 4'd0,
    StNestedGrant   = 4'd1,
    StQueued        = 4'd2,
    StNestedRelease = 4'd3,
    StFreed         = 4'd4,
    StHandedOff     = 4'd5,
    StNotOwner      = 4'd6,
    StQueueErr      = 4'd7,
    StDepthOverflow = 4'd8
  } status_e;

  typedef struct packed {
    logic               command;
    logic [ThreadW-1:0] thread_id;
  } cmd_t;

  typedef struct packed {
    status_e            status;
    logic [ThreadW-1:0] holder_id;
    logic               held;
    logic [7:0]         hold_count;
    logic [4:0]         waiter_count;
  } rsp_t;

endpackage
`default_nettype wire

// ===== design/recursive_lock_fifo_waiters.sv =====
`default_nettype none
// Channel   Ports                       Transfer
// command   start, busy, req_i          start high and busy low at a rising edge
// result    valid_o, rsp_o              valid_o high for one cycle, always taken
//
// Each command runs in steps: the accept cycle reads the waiter memory at the
// queue head, the Exec state decides and writes back; the result strobes in the
// cycle after that, while the next command may already be accepted.
// No new command is taken while busy, until the current one is written back.
// Reset clears lock, pointers, count and waiting mask; the waiter memory needs none.
// The receiver cannot stall; results are never held.
module recursive_lock_fifo_waiters (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rlfw_pkg::cmd_t req_i,
  output logic               valid_o,
  output rlfw_pkg::rsp_t     rsp_o
);

  typedef enum logic {
    Idle,
    Exec
  } state_e;

  localparam logic [rlfw_pkg::DepthBits-1:0] DepthMax = '1;
  localparam logic [rlfw_pkg::DepthBits-1:0] DepthOne = rlfw_pkg::DepthBits'(1);

  state_e state_q;

  logic [rlfw_pkg::ThreadW-1:0] wq_mem [rlfw_pkg::QueueDepth];
  logic [rlfw_pkg::ThreadW-1:0] rdata_q;

  rlfw_pkg::cmd_t cmd_q;

  logic                            held_q, held_d;
  logic [rlfw_pkg::ThreadW-1:0]    owner_q, owner_d;
  logic [rlfw_pkg::DepthBits-1:0]  depth_q, depth_d;
  logic [rlfw_pkg::PtrW-1:0]       head_q, head_d;
  logic [rlfw_pkg::PtrW-1:0]       tail_q, tail_d;
  logic [rlfw_pkg::CntW-1:0]       count_q, count_d;
  logic [rlfw_pkg::NumThreads-1:0] mask_q, mask_d;

  rlfw_pkg::status_e status_d;
  logic              push;
  logic              tid_ok;
  logic              accept;

  function automatic logic [rlfw_pkg::PtrW-1:0] ptr_inc(input logic [rlfw_pkg::PtrW-1:0] p);
    if (p == rlfw_pkg::PtrW'(rlfw_pkg::QueueDepth - 1)) begin
      return '0;
    end
    return p + rlfw_pkg::PtrW'(1);
  endfunction

  assign busy   = (state_q != Idle);
  assign accept = start && !busy;
  assign tid_ok = 32'(cmd_q.thread_id) < rlfw_pkg::NumThreads;

  always_comb begin
    held_d   = held_q;
    owner_d  = owner_q;
    depth_d  = depth_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    mask_d   = mask_q;
    push     = 1'b0;
    status_d = rlfw_pkg::StQueueErr;
    if (cmd_q.command == rlfw_pkg::CmdRelease) begin
      if (!tid_ok || !held_q || owner_q != cmd_q.thread_id) begin
        status_d = rlfw_pkg::StNotOwner;
      end else if (depth_q > DepthOne) begin
        depth_d  = depth_q - DepthOne;
        status_d = rlfw_pkg::StNestedRelease;
      end else if (count_q != '0) begin
        head_d          = ptr_inc(head_q);
        count_d         = count_q - rlfw_pkg::CntW'(1);
        mask_d[rdata_q] = 1'b0;
        owner_d         = rdata_q;
        depth_d         = DepthOne;
        status_d        = rlfw_pkg::StHandedOff;
      end else begin
        held_d   = 1'b0;
        owner_d  = '0;
        depth_d  = '0;
        status_d = rlfw_pkg::StFreed;
      end
    end else begin
      if (!tid_ok) begin
        status_d = rlfw_pkg::StQueueErr;
      end else if (held_q && owner_q == cmd_q.thread_id) begin
        if (depth_q == DepthMax) begin
          status_d = rlfw_pkg::StDepthOverflow;
        end else begin
          depth_d  = depth_q + DepthOne;
          status_d = rlfw_pkg::StNestedGrant;
        end
      end else if (!held_q) begin
        held_d   = 1'b1;
        owner_d  = cmd_q.thread_id;
        depth_d  = DepthOne;
        status_d = rlfw_pkg::StGranted;
      end else if (mask_q[cmd_q.thread_id] ||
                   count_q == rlfw_pkg::CntW'(rlfw_pkg::QueueDepth)) begin
        status_d = rlfw_pkg::StQueueErr;
      end else begin
        push                    = 1'b1;
        tail_d                  = ptr_inc(tail_q);
        count_d                 = count_q + rlfw_pkg::CntW'(1);
        mask_d[cmd_q.thread_id] = 1'b1;
        status_d                = rlfw_pkg::StQueued;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= wq_mem[head_q];
      cmd_q   <= req_i;
    end
    if (state_q == Exec && push) begin
      wq_mem[tail_q] <= cmd_q.thread_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      valid_o <= 1'b0;
      held_q  <= 1'b0;
      owner_q <= '0;
      depth_q <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      mask_q  <= '0;
      rsp_o   <= '0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        Idle: begin
          if (start) begin
            state_q <= Exec;
          end
        end
        Exec: begin
          state_q            <= Idle;
          valid_o            <= 1'b1;
          held_q             <= held_d;
          owner_q            <= owner_d;
          depth_q            <= depth_d;
          head_q             <= head_d;
          tail_q             <= tail_d;
          count_q            <= count_d;
          mask_q             <= mask_d;
          rsp_o.status       <= status_d;
          rsp_o.holder_id    <= held_d ? owner_d : '0;
          rsp_o.held         <= held_d;
          rsp_o.hold_count   <= held_d ? 8'(depth_d) : 8'd0;
          rsp_o.waiter_count <= 5'(count_d);
        end
        default: state_q <= Idle;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !valid_o)
    else $error("accepted command did not enter execution");

  a_strobe_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy && !$past(valid_o))
    else $error("result strobe not a single cycle after execution");

  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mask_q) == 32'(count_q))
    else $error("waiting mask disagrees with queue count");

  a_free_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_q |-> depth_q == '0 && owner_q == '0 && count_q == '0)
    else $error("free lock with owner, depth or waiters");

  a_held_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q |-> depth_q != '0)
    else $error("held lock at zero depth");

endmodule
`default_nettype wire
